@@ rtl/core/utf8_to_utf16_transcoder_assert.svh @@
// Assertion macros for the UTF-8 to UTF-16 transcoder.
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define U8U16_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define U8U16_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U8U16_ASSERT_RST(lbl, prop, msg)
`define U8U16_ASSERT_CLK(lbl, prop, msg)
`endif

`endif

@@ rtl/core/u8u16_pkg.sv @@
// Types, constants and lead byte decode for the UTF-8 to UTF-16 transcoder.
`default_nettype none

package u8u16_pkg;

    localparam logic [15:0] REPL_UNIT = 16'hFFFD;
    localparam logic [15:0] HIGH_SURR = 16'hD800;
    localparam logic [15:0] LOW_SURR  = 16'hDC00;
    localparam logic [15:0] SURR_MASK = 16'hF800;
    localparam logic [20:0] SUPP_BASE = 21'h010000;
    localparam logic [20:0] MAX_POINT = 21'h10FFFF;
    localparam logic [20:0] BMP_TOP   = 21'h00FFFF;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;

    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN1 = 3'd1;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    // One result held in the output stage.
    typedef struct packed {
        logic [15:0] unit;
        logic        repl;
        logic        run_end;
        logic        string_end;
    } slot_t;

    // Outcome of treating a byte as the start of a sequence.
    typedef struct packed {
        logic        emit;
        logic [15:0] unit;
        logic        repl;
        logic [20:0] point;
        logic [2:0]  seq_len;
        logic [1:0]  remaining;
    } lead_t;

    function automatic lead_t decode_lead(input logic [7:0] b, input logic last);
        lead_t r;
        r = '0;
        if (b < ASCII_LIMIT)
        begin
            r.emit = 1'b1;
            r.unit = {8'h00, b};
        end
        else if ((b & LEAD2_MASK) == LEAD2_CODE)
        begin
            r.point     = {16'h0000, b[4:0]};
            r.seq_len   = SEQ_LEN2;
            r.remaining = 2'd1;
        end
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
        begin
            r.point     = {17'h00000, b[3:0]};
            r.seq_len   = SEQ_LEN3;
            r.remaining = 2'd2;
        end
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
        begin
            r.point     = {18'h00000, b[2:0]};
            r.seq_len   = SEQ_LEN4;
            r.remaining = 2'd3;
        end
        else
        begin
            r.emit = 1'b1;
            r.unit = REPL_UNIT;
            r.repl = 1'b1;
        end
        // A sequence that starts on the final byte is cut off at once.
        if (last && r.remaining != 2'd0)
        begin
            r.emit      = 1'b1;
            r.unit      = REPL_UNIT;
            r.repl      = 1'b1;
            r.point     = '0;
            r.seq_len   = SEQ_NONE;
            r.remaining = 2'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/utf8_to_utf16_transcoder.sv @@
// UTF-8 to UTF-16 transcoder: input register, decode logic, two-entry result stage.
//
// Input channel: in_valid/in_ready carry one UTF-8 byte (in_byte) per transfer,
// with string_last set on the final byte of a string.
// Output channel: out_valid/out_ready carry one UTF-16 code unit per transfer.
// is_replacement marks U+FFFD standing for invalid input, run_end marks the
// last unit caused by one byte and string_end the last unit of a string.
// A byte yields zero, one or two units; a supplementary point gives a
// surrogate pair, high unit first.
// The first unit of a byte is presented from the result stage once the byte
// has passed the input register and the decode logic.
// Throughput: one byte per cycle while each byte yields at most one unit and
// the receiver is ready; a byte yielding two units holds back the next byte
// that yields a unit, since the result stage drains one unit per cycle. Bytes
// that only extend a sequence never wait on the output side.
// Reset clears the pending sequence and empties both stages.
// When the receiver stalls, the result stage holds its units and the input
// register holds the next byte that yields a unit, with in_ready low.
`default_nettype none

`include "utf8_to_utf16_transcoder_assert.svh"

module utf8_to_utf16_transcoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        string_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      code_unit,
    output logic             is_replacement,
    output logic             run_end,
    output logic             string_end
);

    // Input register
    logic       a_valid_reg;
    logic [7:0] a_byte_reg;
    logic       a_last_reg;

    // Decoder state
    logic [20:0] point_reg, point_next;
    logic [2:0]  seq_len_reg, seq_len_next;
    logic [1:0]  remain_reg, remain_next;

    // Result stage
    u8u16_pkg::slot_t slot0_reg, slot0_next;
    u8u16_pkg::slot_t slot1_reg, slot1_next;
    logic [1:0]       count_reg, count_next;

    // Decode outputs
    u8u16_pkg::lead_t lead;
    u8u16_pkg::slot_t r0, r1;
    logic [1:0]       n_res;
    logic [20:0]      cp;
    logic [20:0]      supp;
    logic [2:0]       need;
    logic             is_cont;
    logic             bad_point;

    logic a_advance;
    logic out_xfer;
    logic in_xfer;

    always_comb
    begin
        lead         = u8u16_pkg::decode_lead(a_byte_reg, a_last_reg);
        is_cont      = (a_byte_reg[7:6] == 2'b10);
        cp           = {point_reg[14:0], a_byte_reg[5:0]};
        supp         = cp - u8u16_pkg::SUPP_BASE;
        r0           = '0;
        r1           = '0;
        n_res        = 2'd0;
        point_next   = point_reg;
        seq_len_next = seq_len_reg;
        remain_next  = remain_reg;

        if (cp[20:7] == '0)
        begin
            need = u8u16_pkg::SEQ_LEN1;
        end
        else if (cp[20:11] == '0)
        begin
            need = u8u16_pkg::SEQ_LEN2;
        end
        else if (cp[20:16] == '0)
        begin
            need = u8u16_pkg::SEQ_LEN3;
        end
        else
        begin
            need = u8u16_pkg::SEQ_LEN4;
        end

        bad_point = (need != seq_len_reg)
                 || (cp < u8u16_pkg::BMP_TOP
                     && (cp[15:0] & u8u16_pkg::SURR_MASK) == u8u16_pkg::HIGH_SURR)
                 || (cp > u8u16_pkg::MAX_POINT);

        if (remain_reg != 2'd0 && is_cont)
        begin
            if (remain_reg == 2'd1)
            begin
                // Sequence complete: validate and emit.
                n_res = 2'd1;
                if (bad_point)
                begin
                    r0.unit = u8u16_pkg::REPL_UNIT;
                    r0.repl = 1'b1;
                end
                else if (cp[20:16] == '0)
                begin
                    r0.unit = cp[15:0];
                end
                else
                begin
                    r0.unit = u8u16_pkg::HIGH_SURR | {6'd0, supp[19:10]};
                    r1.unit = u8u16_pkg::LOW_SURR | {6'd0, supp[9:0]};
                    n_res   = 2'd2;
                end
                point_next   = '0;
                seq_len_next = u8u16_pkg::SEQ_NONE;
                remain_next  = 2'd0;
            end
            else if (a_last_reg)
            begin
                r0.unit      = u8u16_pkg::REPL_UNIT;
                r0.repl      = 1'b1;
                n_res        = 2'd1;
                point_next   = '0;
                seq_len_next = u8u16_pkg::SEQ_NONE;
                remain_next  = 2'd0;
            end
            else
            begin
                point_next  = cp;
                remain_next = remain_reg - 2'd1;
            end
        end
        else if (remain_reg != 2'd0)
        begin
            // Broken sequence: replace it, then take this byte as a new lead.
            r0.unit      = u8u16_pkg::REPL_UNIT;
            r0.repl      = 1'b1;
            r1.unit      = lead.unit;
            r1.repl      = lead.repl;
            n_res        = lead.emit ? 2'd2 : 2'd1;
            point_next   = lead.point;
            seq_len_next = lead.seq_len;
            remain_next  = lead.remaining;
        end
        else
        begin
            r0.unit      = lead.unit;
            r0.repl      = lead.repl;
            n_res        = lead.emit ? 2'd1 : 2'd0;
            point_next   = lead.point;
            seq_len_next = lead.seq_len;
            remain_next  = lead.remaining;
        end

        if (n_res == 2'd2)
        begin
            r1.run_end    = 1'b1;
            r1.string_end = a_last_reg;
        end
        else
        begin
            r0.run_end    = 1'b1;
            r0.string_end = a_last_reg;
        end
    end

    assign out_xfer  = out_valid && out_ready;
    assign in_xfer   = in_valid && in_ready;
    assign a_advance = a_valid_reg
                    && (n_res == 2'd0 || count_reg == 2'd0
                        || (count_reg == 2'd1 && out_ready));
    assign in_ready  = !a_valid_reg || a_advance;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (a_advance && n_res != 2'd0)
        begin
            slot0_next = r0;
            slot1_next = r1;
            count_next = n_res;
        end
        else if (out_xfer)
        begin
            // Advance the second unit into the output slot.
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            point_reg   <= '0;
            seq_len_reg <= u8u16_pkg::SEQ_NONE;
            remain_reg  <= 2'd0;
            count_reg   <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (a_advance)
            begin
                point_reg   <= point_next;
                seq_len_reg <= seq_len_next;
                remain_reg  <= remain_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            a_byte_reg <= in_byte;
            a_last_reg <= string_last;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign out_valid      = (count_reg != 2'd0);
    assign code_unit      = slot0_reg.unit;
    assign is_replacement = slot0_reg.repl;
    assign run_end        = slot0_reg.run_end;
    assign string_end     = slot0_reg.string_end;

    `U8U16_ASSERT_RST(a_last_clears_seq, (a_advance && a_last_reg) |=> (remain_reg == 2'd0),
        "sequence still pending after the final byte of a string")
    `U8U16_ASSERT_RST(pair_first_not_run_end, (count_reg == 2'd2) |-> !slot0_reg.run_end,
        "first of two pending units is marked as run end")
    `U8U16_ASSERT_RST(surrogate_pair_order,
        (count_reg == 2'd2 && !slot0_reg.repl && slot0_reg.unit[15:10] == 6'b110110)
            |-> (slot1_reg.unit[15:10] == 6'b110111),
        "high surrogate not followed by low surrogate")

endmodule

`default_nettype wire
